// ----- rtl/pmu_battery_status_decoder_defines.svh -----
// Assertion macros shared by the battery status decoder.
`ifndef PMU_BATTERY_STATUS_DECODER_DEFINES_SVH
`define PMU_BATTERY_STATUS_DECODER_DEFINES_SVH

// Checks that a condition holds at every clock edge out of reset.
`define PBSD_CHECK(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pbsd check failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define PBSD_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbsd implication failed");

`endif

// ----- rtl/pbsd_pkg.sv -----
// Package with the constants, types and curve tables of the battery status decoder.
`default_nettype none

package pbsd_pkg;

  localparam logic [7:0]  PBSD_VBUS_BIT     = 8'h20;
  localparam logic [7:0]  PBSD_BATT_BIT     = 8'h08;
  localparam logic [1:0]  PBSD_CHG_CHARGING = 2'b01;
  localparam logic [12:0] PBSD_MV_MIN       = 13'd2500;
  localparam logic [12:0] PBSD_MV_MAX       = 13'd4600;
  localparam logic [7:0]  PBSD_GAUGE_MAX    = 8'd100;
  localparam logic [6:0]  PBSD_PCT_FULL     = 7'd100;
  localparam int          PBSD_CURVE_LEN    = 8;
  localparam int          PBSD_RECIP_SHIFT  = 24;

  typedef struct packed {
    logic report_valid;
    logic usb;
    logic batt;
    logic chg;
    logic gauge_use;
    logic est_use;
  } pbsd_flags_t;

  function automatic logic [12:0] curve_mv(input logic [2:0] idx);
    logic [12:0] v;
    case (idx)
      3'd0: v = 13'd3300;
      3'd1: v = 13'd3600;
      3'd2: v = 13'd3700;
      3'd3: v = 13'd3750;
      3'd4: v = 13'd3850;
      3'd5: v = 13'd3950;
      3'd6: v = 13'd4100;
      3'd7: v = 13'd4200;
      default: v = 13'd4200;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] curve_pct(input logic [2:0] idx);
    logic [6:0] v;
    case (idx)
      3'd0: v = 7'd0;
      3'd1: v = 7'd10;
      3'd2: v = 7'd25;
      3'd3: v = 7'd40;
      3'd4: v = 7'd60;
      3'd5: v = 7'd75;
      3'd6: v = 7'd90;
      3'd7: v = 7'd100;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] seg_pct_span(input logic [2:0] hi);
    logic [6:0] d;
    d = curve_pct(hi) - curve_pct(hi - 3'd1);
    return d[4:0];
  endfunction

  // Reciprocal of the segment's millivolt span, scaled by 2**24 and rounded up.
  // Exact for every product that a segment can produce.
  function automatic logic [18:0] recip_of(input logic [2:0] hi);
    logic [18:0] r;
    case (hi)
      3'd1: r = 19'd55925;
      3'd2: r = 19'd167773;
      3'd3: r = 19'd335545;
      3'd4: r = 19'd167773;
      3'd5: r = 19'd167773;
      3'd6: r = 19'd111849;
      3'd7: r = 19'd167773;
      default: r = 19'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pbsd_estimate.sv -----
// Two-stage voltage-to-percent interpolation over the lithium discharge curve.
`default_nettype none

module pbsd_estimate
  import pbsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [3:0]  count,
  input  wire logic [12:0] mv,
  output logic      [6:0]  q,
  output logic      [6:0]  base
);

  logic [2:0]  seg;
  logic        in_seg;
  logic [12:0] diff;
  logic [8:0]  into;
  logic [13:0] prod_full;
  logic [11:0] prod_nxt;
  logic [6:0]  base_nxt;
  logic [11:0] prod_r;
  logic [6:0]  base1_r;
  logic [2:0]  seg_r;
  logic [30:0] mul_full;
  logic [6:0]  q_r;
  logic [6:0]  base2_r;

  always_comb begin
    seg       = count[2:0];
    in_seg    = (count != 4'd0) && !count[3];
    diff      = mv - curve_mv(seg - 3'd1);
    into      = in_seg ? diff[8:0] : 9'd0;
    prod_full = {5'd0, into} * {9'd0, seg_pct_span(seg)};
    prod_nxt  = prod_full[11:0];
    if (count[3]) begin
      base_nxt = PBSD_PCT_FULL;
    end else if (in_seg) begin
      base_nxt = curve_pct(seg - 3'd1);
    end else begin
      base_nxt = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    base1_r <= base_nxt;
    seg_r   <= seg;
  end

  assign mul_full = {19'd0, prod_r} * {12'd0, recip_of(seg_r)};

  always_ff @(posedge clk) begin
    q_r     <= mul_full[PBSD_RECIP_SHIFT+6:PBSD_RECIP_SHIFT];
    base2_r <= base1_r;
  end

  assign q    = q_r;
  assign base = base2_r;

endmodule

`default_nettype wire

// ----- rtl/pmu_battery_status_decoder.sv -----
// Top level of the battery status decoder: APB register, decode stage, output stage.
//
//   Channel   Ports                           Handshake
//   input     start, busy, in_*               item taken when start is high and busy low
//   result    out_valid, out_*                one-cycle strobe, no back-pressure
//   config    psel, penable, pwrite, paddr,   APB write in access cycle, pready tied high
//             pwdata, prdata, pready
//
// A new item can be taken every cycle; busy is always low.
// Each result reaches the output ports through four register stages: decode and segment
// search, subtract and multiply by the percent span, multiply by the span reciprocal, and
// the final add and select in the output register.
// Reset clears the identified bit and all valid bits in the pipeline.
`default_nettype none
`include "pmu_battery_status_decoder_defines.svh"

module pmu_battery_status_decoder
  import pbsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_status_one,
  input  wire logic        in_status_one_ok,
  input  wire logic [7:0]  in_status_two,
  input  wire logic        in_status_two_ok,
  input  wire logic [7:0]  in_volt_high_byte,
  input  wire logic [7:0]  in_volt_low_byte,
  input  wire logic        in_volt_ok,
  input  wire logic [7:0]  in_gauge_byte,
  input  wire logic        in_gauge_ok,
  output logic             out_valid,
  output logic             out_report_valid,
  output logic             out_usb_present,
  output logic             out_battery_present,
  output logic             out_is_charging,
  output logic      [12:0] out_battery_mv,
  output logic      [6:0]  out_charge_percent,
  output logic             out_percent_valid,
  output logic             out_soc_estimated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic        ident_r;
  logic        cfg_wr;

  logic        accept;
  logic [12:0] raw;
  logic [12:0] mv_nxt;
  logic [3:0]  count_nxt;
  pbsd_flags_t flags_nxt;

  logic        v1_r, v2_r, v3_r;
  pbsd_flags_t flags1_r, flags2_r, flags3_r;
  logic [12:0] mv1_r, mv2_r, mv3_r;
  logic [6:0]  gauge1_r, gauge2_r, gauge3_r;
  logic [3:0]  count1_r;

  logic [6:0]  est_q;
  logic [6:0]  est_base;
  logic [6:0]  est;
  logic [6:0]  pct_nxt;

  logic        out_valid_r;
  pbsd_flags_t out_flags_r;
  logic [12:0] out_mv_r;
  logic [6:0]  out_pct_r;
  logic        out_rest_zero;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {31'd0, ident_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= 1'b0;
    end else if (cfg_wr) begin
      ident_r <= pwdata[0];
    end
  end

  assign accept = start && !busy;

  always_comb begin
    raw                    = {in_volt_high_byte[4:0], in_volt_low_byte};
    flags_nxt.report_valid = ident_r && in_status_one_ok;
    flags_nxt.usb          = flags_nxt.report_valid && ((in_status_one & PBSD_VBUS_BIT) != 8'd0);
    flags_nxt.batt         = flags_nxt.report_valid && ((in_status_one & PBSD_BATT_BIT) != 8'd0);
    flags_nxt.chg          = flags_nxt.report_valid && in_status_two_ok &&
                             (in_status_two[6:5] == PBSD_CHG_CHARGING);
    if (flags_nxt.batt && in_volt_ok && raw >= PBSD_MV_MIN && raw <= PBSD_MV_MAX) begin
      mv_nxt = raw;
    end else begin
      mv_nxt = 13'd0;
    end
    flags_nxt.gauge_use = flags_nxt.batt && in_gauge_ok && (in_gauge_byte <= PBSD_GAUGE_MAX);
    flags_nxt.est_use   = flags_nxt.batt && !flags_nxt.gauge_use && (mv_nxt != 13'd0);
    count_nxt = 4'd0;
    for (int k = 0; k < PBSD_CURVE_LEN; k++) begin
      count_nxt = count_nxt + {3'd0, (mv_nxt > curve_mv(k[2:0]))};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    flags1_r <= flags_nxt;
    mv1_r    <= mv_nxt;
    gauge1_r <= in_gauge_byte[6:0];
    count1_r <= count_nxt;
    flags2_r <= flags1_r;
    mv2_r    <= mv1_r;
    gauge2_r <= gauge1_r;
    flags3_r <= flags2_r;
    mv3_r    <= mv2_r;
    gauge3_r <= gauge2_r;
  end

  pbsd_estimate u_estimate (
    .clk   (clk),
    .count (count1_r),
    .mv    (mv1_r),
    .q     (est_q),
    .base  (est_base)
  );

  always_comb begin
    est = est_base + est_q;
    if (flags3_r.gauge_use) begin
      pct_nxt = gauge3_r;
    end else if (flags3_r.est_use) begin
      pct_nxt = est;
    end else begin
      pct_nxt = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_flags_r <= flags3_r;
    out_mv_r    <= mv3_r;
    out_pct_r   <= pct_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_report_valid    = out_flags_r.report_valid;
  assign out_usb_present     = out_flags_r.usb;
  assign out_battery_present = out_flags_r.batt;
  assign out_is_charging     = out_flags_r.chg;
  assign out_battery_mv      = out_mv_r;
  assign out_charge_percent  = out_pct_r;
  assign out_percent_valid   = out_flags_r.gauge_use || out_flags_r.est_use;
  assign out_soc_estimated   = out_flags_r.est_use;

  assign out_rest_zero = !out_usb_present && !out_battery_present && !out_is_charging &&
                         (out_battery_mv == 13'd0) && !out_percent_valid;

  `PBSD_IMPLY(a_latency, out_valid, $past(start, 4))
  `PBSD_IMPLY(a_est_needs_mv, out_valid && out_soc_estimated, out_percent_valid && |out_battery_mv)
  `PBSD_IMPLY(a_no_report_zero, out_valid && !out_report_valid, out_rest_zero)
  `PBSD_CHECK(a_pct_range, !out_valid || out_charge_percent <= 7'd100)

endmodule

`default_nettype wire
